// ===== src/acm_pkg.sv =====
// Shared types and constants for the keyword masker.
`timescale 1ns / 1ps
package acm_pkg;

  localparam int ALPHABET = 256;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_KEYWORD = 2'd1,
    CMD_BUILD   = 2'd2,
    CMD_SCAN    = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] CFG_LEAD_LOW  = 2'd0;
  localparam logic [1:0] CFG_LEAD_HIGH = 2'd1;
  localparam logic [1:0] CFG_MASK_BYTE = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       end_mark;
  } in_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] text_out;
    logic       text_last;
    logic [1:0] status_code;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_STAT,
    S_LK0,
    S_LK1,
    S_LK2,
    S_KEY,
    S_FAIL,
    S_B_POP,
    S_B_NODE,
    S_B_GOT,
    S_B_WALK,
    S_B_SET,
    S_B_NEXT,
    S_S_GOT,
    S_S_OUT,
    S_S_LEN,
    S_S_EMIT
  } state_t;

endpackage

// ===== src/acm_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
module acm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/aho_corasick_keyword_masker_unit.sv =====
// Top level of the keyword masker: command sequencer, trie memories and delay window.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready, in_data): one command per request: clear, keyword
//   byte, build links, or scan a text byte. One request is worked on at a time.
//   Output channel (out_valid/out_ready, out_data): one status per clear, keyword or build
//   request; scan requests give zero or more text bytes, a whole window on end_mark.
//   Config port (cfg_we, cfg_index, cfg_wdata): lead range and mask byte, idle only.
// Sequencing
//   Clear: straight to the status. Keyword byte: goto read, parent check, write back.
//   Scan byte: a goto lookup, plus one per failure hop and one per output-chain hop,
//   then any bytes sent out. Build: one goto lookup per (node, byte) pair, all through
//   the single goto read port.
// Reset
//   Synchronous active-low; the trie is empty at once: a goto entry counts only if its
//   child was allocated since the last clear and its parent record matches, so no
//   clearing pass is run.
// Stall
//   Results sit in an output register; the sequencer waits to place one while it is occupied.
module aho_corasick_keyword_masker_unit
  import acm_pkg::*;
#(
  parameter int MAX_NODES   = 512,
  parameter int MAX_KEY_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int LW = $clog2(MAX_KEY_LEN + 1);
  localparam int IW = $clog2(MAX_KEY_LEN);
  localparam int GD = MAX_NODES * ALPHABET;
  localparam int GW = $clog2(GD);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [NW:0]   nodes_r, nodes_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0] cursor_r, cursor_nxt, scan_r, scan_nxt;
  logic [NW-1:0] p_r, p_nxt, node_r, node_nxt, c_r, c_nxt, child_r, child_nxt;
  logic [NW-1:0] ch_r, ch_nxt, f_r, f_nxt, t_r, t_nxt;
  logic [LW-1:0] depth_r, depth_nxt, fill_r, fill_nxt;
  logic [1:0]    abort_r, abort_nxt, st_r, st_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          em_r, em_nxt, cb_r, cb_nxt;
  logic [7:0]    lead_low_r, lead_high_r, mask_r;
  logic [7:0]    win_r [MAX_KEY_LEN];
  logic [7:0]    win_nxt [MAX_KEY_LEN];
  out_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  // memory ports
  logic          g_we;
  logic [GW-1:0] g_waddr, g_raddr;
  logic [NW-1:0] g_wdata, g_rdata;
  logic          pb_we;
  logic [NW-1:0] pb_waddr, pb_raddr;
  logic [NW+7:0] pb_wdata, pb_rdata;
  logic          fl_we;
  logic [NW-1:0] fl_waddr, fl_wdata, fl_raddr, fl_rdata;
  logic          ln_we;
  logic [NW-1:0] ln_waddr, ln_raddr;
  logic [LW-1:0] ln_wdata, ln_rdata;
  logic          q_we;
  logic [NW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

  acm_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
    .clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );
  acm_ram #(.WIDTH(NW + 8), .DEPTH(MAX_NODES)) u_parent (
    .clk, .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata), .raddr(pb_raddr),
    .rdata(pb_rdata)
  );
  acm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
    .clk, .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata), .raddr(fl_raddr),
    .rdata(fl_rdata)
  );
  acm_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_len (
    .clk, .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata), .raddr(ln_raddr),
    .rdata(ln_rdata)
  );
  acm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );

  logic can_emit;
  logic lead;
  assign can_emit  = !out_valid_r || out_ready;
  assign lead      = (in_data.data_byte >= lead_low_r) && (in_data.data_byte <= lead_high_r);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [1:0]    st_k;
    logic [NW-1:0] ch_k;
    logic          alloc;
    logic [LW-1:0] lenc;
    logic [LW:0]   sum;
    state_nxt = state_r;   ret_nxt = ret_r;
    nodes_nxt = nodes_r;   head_nxt = head_r;   tail_nxt = tail_r;
    cursor_nxt = cursor_r; scan_nxt = scan_r;
    p_nxt = p_r; node_nxt = node_r; c_nxt = c_r; child_nxt = child_r;
    ch_nxt = ch_r; f_nxt = f_r; t_nxt = t_r;
    depth_nxt = depth_r; fill_nxt = fill_r; abort_nxt = abort_r; st_nxt = st_r;
    byte_nxt = byte_r; em_nxt = em_r; cb_nxt = cb_r;
    win_nxt = win_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    st_k = st_r; ch_k = child_r; alloc = 1'b0;
    lenc = '0; sum = '0;
    g_we = 1'b0;  g_waddr = {cursor_r, byte_r}; g_wdata = nodes_r[NW-1:0];
    g_raddr = {p_r, byte_r};
    pb_we = 1'b0; pb_waddr = nodes_r[NW-1:0]; pb_wdata = {cursor_r, byte_r};
    pb_raddr = g_rdata;
    fl_we = 1'b0; fl_waddr = nodes_r[NW-1:0]; fl_wdata = '0; fl_raddr = p_r;
    ln_we = 1'b0; ln_waddr = nodes_r[NW-1:0]; ln_wdata = '0; ln_raddr = t_r;
    q_we = 1'b0;  q_waddr = '0; q_wdata = '0; q_raddr = tail_r[NW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.data_byte;
          em_nxt   = in_data.end_mark;
          case (in_data.command)
            CMD_CLEAR: begin
              nodes_nxt  = (NW + 1)'(1);
              cursor_nxt = '0;
              depth_nxt  = '0;
              abort_nxt  = ST_OK;
              scan_nxt   = '0;
              st_nxt     = ST_OK;
              state_nxt  = S_STAT;
            end
            CMD_KEYWORD: begin
              p_nxt   = cursor_r;
              ret_nxt = S_KEY;
              if (abort_r != ST_OK) begin
                st_nxt    = abort_r;
                state_nxt = S_KEY;
              end else if (depth_r >= LW'(MAX_KEY_LEN)) begin
                st_nxt    = ST_TOO_LONG;
                state_nxt = S_KEY;
              end else begin
                st_nxt    = ST_OK;
                state_nxt = S_LK0;
              end
            end
            CMD_BUILD: begin
              q_we      = 1'b1;
              q_waddr   = '0;
              q_wdata   = '0;
              head_nxt  = (NW + 1)'(1);
              tail_nxt  = '0;
              state_nxt = S_B_POP;
            end
            default: begin
              win_nxt[fill_r[IW-1:0]] = in_data.data_byte;
              fill_nxt  = fill_r + LW'(1);
              cb_nxt    = !(cb_r && lead);
              p_nxt     = scan_r;
              ret_nxt   = S_S_GOT;
              state_nxt = S_LK0;
            end
          endcase
        end
      end

      S_STAT: begin
        if (can_emit) begin
          out_nxt.result_kind = KIND_STATUS;
          out_nxt.text_out    = '0;
          out_nxt.text_last   = 1'b0;
          out_nxt.status_code = st_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      // child lookup of (p_r, byte_r): goto read, then parent record check
      S_LK0: state_nxt = S_LK1;
      S_LK1: begin
        c_nxt     = g_rdata;
        state_nxt = S_LK2;
      end
      S_LK2: begin
        if (c_r != '0 && {1'b0, c_r} < nodes_r && pb_rdata == {p_r, byte_r}) begin
          child_nxt = c_r;
        end else begin
          child_nxt = '0;
        end
        state_nxt = ret_r;
      end

      S_KEY: begin
        if (st_r == ST_OK) begin
          if (child_r == '0) begin
            if (nodes_r >= (NW + 1)'(MAX_NODES)) begin
              st_k = ST_FULL;
            end else begin
              alloc     = 1'b1;
              ch_k      = nodes_r[NW-1:0];
              nodes_nxt = nodes_r + (NW + 1)'(1);
            end
          end
          if (st_k == ST_OK) begin
            cursor_nxt = ch_k;
            depth_nxt  = depth_r + LW'(1);
          end
        end
        if (st_k != ST_OK) begin
          abort_nxt = st_k;
        end
        g_we  = alloc;
        pb_we = alloc;
        fl_we = alloc;
        ln_waddr = cursor_nxt;
        ln_we    = alloc || (em_r && abort_nxt == ST_OK);
        ln_wdata = (em_r && abort_nxt == ST_OK) ? depth_nxt : '0;
        if (em_r) begin
          cursor_nxt = '0;
          depth_nxt  = '0;
          abort_nxt  = ST_OK;
        end
        st_nxt    = st_k;
        state_nxt = S_STAT;
      end

      // follow one failure link; return path kept in ret_r
      S_FAIL: begin
        p_nxt     = fl_rdata;
        state_nxt = S_LK0;
      end

      S_B_POP: begin
        if (tail_r < head_r) begin
          state_nxt = S_B_NODE;
        end else begin
          st_nxt    = ST_OK;
          state_nxt = S_STAT;
        end
      end
      S_B_NODE: begin
        node_nxt  = q_rdata;
        p_nxt     = q_rdata;
        tail_nxt  = tail_r + (NW + 1)'(1);
        byte_nxt  = '0;
        ret_nxt   = S_B_GOT;
        state_nxt = S_LK0;
      end
      S_B_GOT: begin
        if (child_r == '0) begin
          state_nxt = S_B_NEXT;
        end else begin
          ch_nxt = child_r;
          f_nxt  = '0;
          if (node_r == '0) begin
            state_nxt = S_B_SET;
          end else begin
            fl_raddr  = node_r;
            ret_nxt   = S_B_WALK;
            state_nxt = S_FAIL;
          end
        end
      end
      S_B_WALK: begin
        if (child_r != '0) begin
          f_nxt     = child_r;
          state_nxt = S_B_SET;
        end else if (p_r == '0) begin
          state_nxt = S_B_SET;
        end else begin
          fl_raddr  = p_r;
          state_nxt = S_FAIL;
        end
      end
      S_B_SET: begin
        fl_we    = 1'b1;
        fl_waddr = ch_r;
        fl_wdata = f_r;
        if (head_r < (NW + 1)'(MAX_NODES)) begin
          q_we     = 1'b1;
          q_waddr  = head_r[NW-1:0];
          q_wdata  = ch_r;
          head_nxt = head_r + (NW + 1)'(1);
        end
        state_nxt = S_B_NEXT;
      end
      S_B_NEXT: begin
        if (byte_r == 8'hFF) begin
          state_nxt = S_B_POP;
        end else begin
          byte_nxt  = byte_r + 8'd1;
          p_nxt     = node_r;
          ret_nxt   = S_B_GOT;
          state_nxt = S_LK0;
        end
      end

      S_S_GOT: begin
        if (child_r != '0 || p_r == '0) begin
          scan_nxt  = child_r;
          t_nxt     = child_r;
          state_nxt = S_S_OUT;
        end else begin
          fl_raddr  = p_r;
          state_nxt = S_FAIL;
        end
      end
      S_S_OUT: begin
        fl_raddr = t_r;
        if (t_r == '0) begin
          state_nxt = S_S_EMIT;
        end else begin
          state_nxt = S_S_LEN;
        end
      end
      S_S_LEN: begin
        if (ln_rdata > LW'(1)) begin
          if (cb_r) begin
            lenc = (ln_rdata > fill_r) ? fill_r : ln_rdata;
            for (int k = 0; k < MAX_KEY_LEN; k++) begin
              sum = (LW + 1)'(k) + {1'b0, lenc};
              if (LW'(k) < fill_r && sum >= {1'b0, fill_r}) begin
                win_nxt[k] = mask_r;
              end
            end
          end
          state_nxt = S_S_EMIT;
        end else begin
          t_nxt     = fl_rdata;
          state_nxt = S_S_OUT;
        end
      end
      S_S_EMIT: begin
        if (em_r && fill_r == '0) begin
          scan_nxt  = '0;
          cb_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (em_r || fill_r >= LW'(MAX_KEY_LEN)) begin
          if (can_emit) begin
            out_nxt.result_kind = KIND_TEXT;
            out_nxt.text_out    = win_r[0];
            out_nxt.text_last   = em_r && (fill_r == LW'(1));
            out_nxt.status_code = ST_OK;
            out_valid_nxt       = 1'b1;
            for (int k = 0; k < MAX_KEY_LEN - 1; k++) begin
              win_nxt[k] = win_r[k+1];
            end
            fill_nxt = fill_r - LW'(1);
            if (!em_r) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      nodes_r     <= (NW + 1)'(1);
      cursor_r    <= '0;
      depth_r     <= '0;
      abort_r     <= ST_OK;
      scan_r      <= '0;
      fill_r      <= '0;
      cb_r        <= 1'b1;
      out_valid_r <= 1'b0;
      lead_low_r  <= 8'd128;
      lead_high_r <= 8'd255;
      mask_r      <= 8'd42;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      nodes_r     <= nodes_nxt;
      cursor_r    <= cursor_nxt;
      depth_r     <= depth_nxt;
      abort_r     <= abort_nxt;
      scan_r      <= scan_nxt;
      fill_r      <= fill_nxt;
      cb_r        <= cb_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEAD_LOW:  lead_low_r  <= cfg_wdata;
          CFG_LEAD_HIGH: lead_high_r <= cfg_wdata;
          CFG_MASK_BYTE: mask_r      <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    p_r     <= p_nxt;
    node_r  <= node_nxt;
    c_r     <= c_nxt;
    child_r <= child_nxt;
    ch_r    <= ch_nxt;
    f_r     <= f_nxt;
    t_r     <= t_nxt;
    st_r    <= st_nxt;
    byte_r  <= byte_nxt;
    em_r    <= em_nxt;
    win_r   <= win_nxt;
    out_r   <= out_nxt;
  end

  // window never left full between requests
  a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (fill_r < LW'(MAX_KEY_LEN)))
    else $error("delay window full while idle");

  a_clear_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_CLEAR) |=> (nodes_r == (NW + 1)'(1)))
    else $error("clear did not reset node count");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_B_POP) |-> (tail_r <= head_r && head_r <= nodes_r))
    else $error("breadth-first queue pointers out of order");

endmodule

// ===== tb/sv/tb_aho_corasick_keyword_masker_unit.sv =====
// Testbench for the keyword masker: trie commands and text scans checked against a predictor.
`timescale 1ns / 1ps
module tb_aho_corasick_keyword_masker_unit
  import acm_pkg::*;
;

  localparam int NODES   = 512;
  localparam int KEY_MAX = 32;
  localparam int LIMIT   = 3000000;
  localparam int SETTLE  = 400;

  class masker_scoreboard;
    bit [8:0] goto_map[int];
    bit [8:0] fail_of[NODES];
    bit [5:0] len_of[NODES];
    int       nodes_used, cursor, depth, abort_code, scan_at, fill;
    bit [7:0] window[KEY_MAX];
    bit       boundary;
    bit [7:0] lead_lo, lead_hi, mask_val;
    out_t     awaited[$];
    int       errors, texts_seen, statuses_seen;

    function new();
      lead_lo = 8'd128; lead_hi = 8'd255; mask_val = 8'd42;
      fill = 0; boundary = 1; errors = 0; texts_seen = 0; statuses_seen = 0;
      wipe_trie();
    endfunction

    function void wipe_trie();
      goto_map.delete();
      foreach (fail_of[i]) begin fail_of[i] = '0; len_of[i] = '0; end
      nodes_used = 1; cursor = 0; depth = 0; abort_code = 0; scan_at = 0;
    endfunction

    function int child(int n, int b);
      int k;
      k = n * ALPHABET + b;
      return goto_map.exists(k) ? int'(goto_map[k]) : 0;
    endfunction

    function void set_reg(logic [1:0] idx, bit [7:0] v);
      case (idx)
        CFG_LEAD_LOW:  lead_lo = v;
        CFG_LEAD_HIGH: lead_hi = v;
        CFG_MASK_BYTE: mask_val = v;
        default: ;
      endcase
    endfunction

    function void push_status(logic [1:0] st);
      out_t r;
      r = '0; r.result_kind = KIND_STATUS; r.status_code = st;
      awaited.push_back(r);
    endfunction

    function void push_text(bit [7:0] b, bit last);
      out_t r;
      r = '0; r.result_kind = KIND_TEXT; r.text_out = b; r.text_last = last;
      awaited.push_back(r);
    endfunction

    function void link_failures();
      int bq[$];
      int node, ch, f, p, g;
      bq.push_back(0);
      while (bq.size() > 0) begin
        node = bq.pop_front();
        for (int i = 0; i < ALPHABET; i++) begin
          ch = child(node, i);
          if (ch == 0) continue;
          f = 0;
          if (node != 0) begin
            p = fail_of[node];
            for (g = 0; g <= NODES; g++) begin
              if (child(p, i) != 0) begin f = child(p, i); break; end
              if (p == 0) break;
              p = fail_of[p];
            end
          end
          fail_of[ch] = 9'(f);
          bq.push_back(ch);
        end
      end
    endfunction

    function logic [1:0] add_key_byte(int b, bit em);
      int st, ch;
      if (abort_code != 0) st = abort_code;
      else if (depth >= KEY_MAX) st = ST_TOO_LONG;
      else begin
        st = ST_OK;
        ch = child(cursor, b);
        if (ch == 0) begin
          if (nodes_used >= NODES) st = ST_FULL;
          else begin
            ch = nodes_used++;
            goto_map[cursor * ALPHABET + b] = 9'(ch);
            fail_of[ch] = '0; len_of[ch] = '0;
          end
        end
        if (st == ST_OK) begin cursor = ch; depth++; end
      end
      if (st != 0) abort_code = st;
      if (em) begin
        if (abort_code == 0) len_of[cursor] = 6'(depth);
        cursor = 0; depth = 0; abort_code = 0;
      end
      return 2'(st);
    endfunction

    function void scan_text(int b, bit em);
      int p, t, len, g;
      bit lead;
      lead = (b >= lead_lo) && (b <= lead_hi);
      if (fill >= KEY_MAX) fill = KEY_MAX - 1;
      window[fill++] = 8'(b);
      boundary = !(boundary && lead);
      p = scan_at;
      for (g = 0; g <= NODES && p != 0 && child(p, b) == 0; g++) p = fail_of[p];
      p = child(p, b);
      scan_at = p;
      t = p;
      for (g = 0; g <= NODES && t != 0; g++) begin
        len = len_of[t];
        if (len > 1) begin
          if (boundary) begin
            if (len > fill) len = fill;
            for (int i = fill - len; i < fill; i++) window[i] = mask_val;
          end
          break;
        end
        t = fail_of[t];
      end
      if (em) begin
        for (int i = 0; i < fill; i++) push_text(window[i], i + 1 == fill);
        fill = 0; scan_at = 0; boundary = 1;
      end else if (fill >= KEY_MAX) begin
        push_text(window[0], 1'b0);
        for (int i = 0; i < KEY_MAX - 1; i++) window[i] = window[i + 1];
        fill = KEY_MAX - 1;
      end
    endfunction

    // works out what one accepted request must produce
    function void note_request(in_t d);
      case (cmd_t'(d.command))
        CMD_CLEAR:   begin wipe_trie(); push_status(ST_OK); end
        CMD_KEYWORD: push_status(add_key_byte(d.data_byte, d.end_mark));
        CMD_BUILD:   begin link_failures(); push_status(ST_OK); end
        default:     scan_text(d.data_byte, d.end_mark);
      endcase
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = awaited.pop_front();
      if (got.result_kind == KIND_TEXT) texts_seen++; else statuses_seen++;
      if (got.result_kind !== want.result_kind)
        report($sformatf("result_kind %0d, want %0d", got.result_kind, want.result_kind));
      if (got.text_out !== want.text_out)
        report($sformatf("text_out %0h, want %0h", got.text_out, want.text_out));
      if (got.text_last !== want.text_last)
        report($sformatf("text_last %0d, want %0d", got.text_last, want.text_last));
      if (got.status_code !== want.status_code)
        report($sformatf("status_code %0d, want %0d", got.status_code, want.status_code));
    endtask
  endclass

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready;
  in_t        in_data;
  out_t       out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  masker_scoreboard sb;
  bit  calm;
  int  hold_req;
  int  cycles;
  int  sent;
  byte unsigned favourites[6] = '{8'h61, 8'h62, 8'h81, 8'h40, 8'h00, 8'hFF};

  aho_corasick_keyword_masker_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit [7:0] pick_byte();
    if ($urandom_range(0, 7) < 5) return favourites[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.awaited.size());
      $display("** aho_corasick_keyword_masker_unit: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold when asked
  initial begin
    int gap;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send(logic [1:0] cmd, bit [7:0] b, bit em);
    in_t d;
    int  gap;
    d.command = cmd; d.data_byte = b; d.end_mark = em;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_request(d);
    sent++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(bit [7:0] lo, bit [7:0] hi, bit [7:0] mk);
    bit [7:0] vals[3];
    vals = '{lo, hi, mk};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(i[1:0], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_key(byte unsigned k[$]);
    foreach (k[i]) send(CMD_KEYWORD, k[i], i == k.size() - 1);
  endtask

  task automatic send_text(byte unsigned s[$]);
    foreach (s[i]) send(CMD_SCAN, s[i], i == s.size() - 1);
  endtask

  initial begin
    byte unsigned k[$];
    int n, len, kind;
    sb = new();
    cycles = 0; sent = 0; calm = 0; hold_req = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short keywords, zero byte, single-byte key, lead pair, extremes
    set_regs(8'h80, 8'hFF, 8'h2A);
    send(CMD_CLEAR, 8'h00, 1'b0);
    send_key('{8'h61, 8'h62});
    send_key('{8'h62, 8'h00});
    send_key('{8'h78});
    send_key('{8'h81, 8'h40});
    send(CMD_BUILD, 8'hFF, 1'b1);
    send_key('{8'hFF, 8'h61});          // unbuilt node, fails to root
    send_text('{8'h78, 8'h61, 8'h62, 8'h00, 8'hFF, 8'h61});
    send_text('{8'h81, 8'h40});
    send_text('{8'h20, 8'h81, 8'h40, 8'h81});
    k = {};
    for (int i = 0; i < KEY_MAX + 1; i++) k.push_back(8'h30);
    send_key(k);                         // one byte too many
    drain_and_settle();
    set_regs(8'hFF, 8'h00, 8'h00);       // empty lead range
    send_text('{8'h81, 8'h40, 8'h61, 8'h62});

    // long hold on the result side while a long string keeps coming
    drain_and_settle();
    hold_req = 600;
    k = {};
    for (int i = 0; i < 40; i++) k.push_back(pick_byte());
    send_text(k);
    drain_and_settle();

    // random phases: settings, clear, keywords, build, scanned strings, noise
    n = 0;
    for (int ph = 0; n < 60; ph++) begin
      calm = (ph % 3 == 2);
      case (ph % 4)
        0: set_regs(8'h00, 8'hFF, 8'hFF);
        1: set_regs(8'hFF, 8'h00, 8'($urandom_range(0, 255)));
        default: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
      endcase
      send(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(2, 5)) begin
        k = {};
        len = $urandom_range(0, 9) == 0 ? KEY_MAX + 2 : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) k.push_back(pick_byte());
        send_key(k);
        n += len;
      end
      send(CMD_BUILD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(3, 6)) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
          n++;
        end else begin
          k = {};
          len = kind == 1 ? $urandom_range(33, 45) : $urandom_range(1, 12);
          for (int i = 0; i < len; i++) k.push_back(pick_byte());
          send_text(k);
          n += len;
        end
      end
      drain_and_settle();
    end
    calm = 0;

    drain_and_settle();
    $display("Covered %0d requests: %0d text bytes and %0d statuses checked,", sent,
             sb.texts_seen, sb.statuses_seen);
    $display("  incl. overlong keys, an empty lead range and a long stall.");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("** aho_corasick_keyword_masker_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.errors, sb.awaited.size());
      $display("** aho_corasick_keyword_masker_unit: FAILED **");
    end
    $finish;
  end

endmodule
